>>> rtl/text_glyph_layout_assert.svh
// ---------------------------------------------------------------------------
// text glyph layout assertion macros
// shared property forms for the layout block's concurrent checks
// ---------------------------------------------------------------------------
`ifndef TEXT_GLYPH_LAYOUT_ASSERT_SVH
`define TEXT_GLYPH_LAYOUT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TGL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("text_glyph_layout: same-cycle check failed");

// next-cycle implication, checked out of reset
`define TGL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("text_glyph_layout: next-cycle check failed");

`endif

>>> rtl/tgl_pkg.sv
// ---------------------------------------------------------------------------
// tgl_pkg
// types, constants and character codes of the text glyph layout block
// ---------------------------------------------------------------------------
`default_nettype none

package tgl_pkg;

    localparam int TGL_MAX_GLYPHS  = 1024;
    localparam int TGL_QUEUE_DEPTH = 4;
    localparam int TGL_CFG_IDX_W   = 3;

    // register indexes of the configuration port
    localparam logic [TGL_CFG_IDX_W-1:0] CFG_START_X     = 3'd0;
    localparam logic [TGL_CFG_IDX_W-1:0] CFG_START_Y     = 3'd1;
    localparam logic [TGL_CFG_IDX_W-1:0] CFG_LINE_SIZE   = 3'd2;
    localparam logic [TGL_CFG_IDX_W-1:0] CFG_GLYPH_SCALE = 3'd3;
    localparam logic [TGL_CFG_IDX_W-1:0] CFG_INV_ASPECT  = 3'd4;

    // configuration reset values
    localparam logic [31:0] RST_START_X     = 32'd0;
    localparam logic [31:0] RST_START_Y     = 32'd0;
    localparam logic [30:0] RST_LINE_SIZE   = 31'd1048576;
    localparam logic [31:0] RST_GLYPH_SCALE = 32'd65536;
    localparam logic [31:0] RST_INV_ASPECT  = 32'd65536;

    // control characters
    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
    localparam logic [7:0] CHAR_RETURN    = 8'h0D;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    // escape letters and digits
    localparam logic [7:0] ESC_CHAR_RED    = 8'h72;
    localparam logic [7:0] ESC_CHAR_GREEN  = 8'h67;
    localparam logic [7:0] ESC_CHAR_BLUE   = 8'h62;
    localparam logic [7:0] ESC_CHAR_WHITE  = 8'h77;
    localparam logic [7:0] ESC_CHAR_YELLOW = 8'h79;
    localparam logic [7:0] ESC_CHAR_CYAN   = 8'h63;
    localparam logic [7:0] ESC_CHAR_PURPLE = 8'h70;
    localparam logic [7:0] ESC_CHAR_ZERO   = 8'h30;
    localparam logic [7:0] ESC_CHAR_ONE    = 8'h31;
    localparam logic [7:0] ESC_CHAR_TWO    = 8'h32;
    localparam logic [7:0] ESC_CHAR_THREE  = 8'h33;
    localparam logic [7:0] ESC_CHAR_FOUR   = 8'h34;

    // colour codes, bit0 red, bit1 green, bit2 blue
    localparam logic [2:0] COLOUR_RED    = 3'd1;
    localparam logic [2:0] COLOUR_GREEN  = 3'd2;
    localparam logic [2:0] COLOUR_YELLOW = 3'd3;
    localparam logic [2:0] COLOUR_BLUE   = 3'd4;
    localparam logic [2:0] COLOUR_PURPLE = 3'd5;
    localparam logic [2:0] COLOUR_CYAN   = 3'd6;
    localparam logic [2:0] COLOUR_WHITE  = 3'd7;

    localparam logic [2:0] LEVEL_FULL = 3'd4;

    // meaning of a character outside an escape
    typedef enum logic [2:0] {
        KIND_GLYPH,
        KIND_NEWLINE,
        KIND_RETURN,
        KIND_BACKSPACE,
        KIND_ESCAPE,
        KIND_NUL
    } char_kind_t;

    // meaning of a character right after a backslash
    typedef enum logic [1:0] {
        ESC_GLYPH,
        ESC_COLOUR,
        ESC_LEVEL
    } esc_kind_t;

    typedef struct packed {
        logic [31:0] start_x;
        logic [31:0] start_y;
        logic [30:0] line_size;
        logic [31:0] glyph_scale;
        logic [31:0] inv_aspect;
    } cfg_t;

    // classified character with its glyph size, as queued between front and back
    typedef struct packed {
        logic        new_string;
        char_kind_t  kind;
        esc_kind_t   esc_kind;
        logic [2:0]  esc_value;
        logic [15:0] tex_left;
        logic [15:0] tex_bottom;
        logic [15:0] tex_width;
        logic [15:0] tex_height;
        logic [31:0] quad_width;
        logic [31:0] quad_height;
    } item_t;

    typedef struct packed {
        logic [9:0]  icon_slot;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] quad_width;
        logic [31:0] quad_height;
        logic [15:0] tex_left;
        logic [15:0] tex_bottom;
        logic [15:0] tex_width;
        logic [15:0] tex_height;
        logic [2:0]  colour_bits;
        logic [2:0]  intensity_level;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/tgl_front.sv
// ---------------------------------------------------------------------------
// tgl_front
// classifies characters and sizes glyph quads in a two-stage pipeline
// ---------------------------------------------------------------------------
`default_nettype none

module tgl_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire tgl_pkg::cfg_t  cfg,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           in_new_string,
    input  wire logic [7:0]     in_char,
    input  wire logic [15:0]    in_u,
    input  wire logic [15:0]    in_v,
    input  wire logic [15:0]    in_w,
    input  wire logic [15:0]    in_h,
    output logic                out_valid,
    input  wire logic           out_ready,
    output tgl_pkg::item_t      out_item
);
    import tgl_pkg::*;

    function automatic char_kind_t plain_kind(input logic [7:0] c);
        char_kind_t k;
        unique case (c)
            CHAR_NEWLINE:   k = KIND_NEWLINE;
            CHAR_RETURN:    k = KIND_RETURN;
            CHAR_BACKSPACE: k = KIND_BACKSPACE;
            CHAR_BACKSLASH: k = KIND_ESCAPE;
            CHAR_NUL:       k = KIND_NUL;
            default:        k = KIND_GLYPH;
        endcase
        return k;
    endfunction

    logic        valid1_reg, valid2_reg;
    item_t       item1_reg, item2_reg;
    item_t       item2_next;
    logic [31:0] pw1_reg;
    logic        adv1, adv2;
    item_t       item_in;
    logic [63:0] qw_full;

    assign adv2     = !valid2_reg || out_ready;
    assign adv1     = !valid1_reg || adv2;
    assign in_ready = adv1;

    // decode both readings of the character, the back picks by escape state
    always_comb begin
        item_in             = '0;
        item_in.new_string  = in_new_string;
        item_in.kind        = plain_kind(in_char);
        item_in.esc_kind    = ESC_GLYPH;
        item_in.esc_value   = '0;
        item_in.tex_left    = in_u;
        item_in.tex_bottom  = in_v;
        item_in.tex_width   = in_w;
        item_in.tex_height  = in_h;
        item_in.quad_width  = '0;
        item_in.quad_height = 32'((48'(cfg.glyph_scale) * 48'(in_h)) >> 16);
        unique case (in_char)
            ESC_CHAR_RED: begin
                item_in.esc_kind  = ESC_COLOUR;
                item_in.esc_value = COLOUR_RED;
            end
            ESC_CHAR_GREEN: begin
                item_in.esc_kind  = ESC_COLOUR;
                item_in.esc_value = COLOUR_GREEN;
            end
            ESC_CHAR_BLUE: begin
                item_in.esc_kind  = ESC_COLOUR;
                item_in.esc_value = COLOUR_BLUE;
            end
            ESC_CHAR_WHITE: begin
                item_in.esc_kind  = ESC_COLOUR;
                item_in.esc_value = COLOUR_WHITE;
            end
            ESC_CHAR_YELLOW: begin
                item_in.esc_kind  = ESC_COLOUR;
                item_in.esc_value = COLOUR_YELLOW;
            end
            ESC_CHAR_CYAN: begin
                item_in.esc_kind  = ESC_COLOUR;
                item_in.esc_value = COLOUR_CYAN;
            end
            ESC_CHAR_PURPLE: begin
                item_in.esc_kind  = ESC_COLOUR;
                item_in.esc_value = COLOUR_PURPLE;
            end
            ESC_CHAR_ZERO: begin
                item_in.esc_kind  = ESC_LEVEL;
                item_in.esc_value = 3'd0;
            end
            ESC_CHAR_ONE: begin
                item_in.esc_kind  = ESC_LEVEL;
                item_in.esc_value = 3'd1;
            end
            ESC_CHAR_TWO: begin
                item_in.esc_kind  = ESC_LEVEL;
                item_in.esc_value = 3'd2;
            end
            ESC_CHAR_THREE: begin
                item_in.esc_kind  = ESC_LEVEL;
                item_in.esc_value = 3'd3;
            end
            ESC_CHAR_FOUR: begin
                item_in.esc_kind  = ESC_LEVEL;
                item_in.esc_value = 3'd4;
            end
            default: begin
                item_in.esc_kind  = ESC_GLYPH;
                item_in.esc_value = 3'd0;
            end
        endcase
    end

    // second multiply, saturated to 32 bits after the shift
    assign qw_full = 64'(pw1_reg) * 64'(cfg.inv_aspect);

    always_comb begin
        item2_next = item1_reg;
        if (qw_full[63:48] != 16'd0) begin
            item2_next.quad_width = 32'hFFFF_FFFF;
        end else begin
            item2_next.quad_width = qw_full[47:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                valid1_reg <= in_valid;
            end
            if (adv2) begin
                valid2_reg <= valid1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && in_valid) begin
            item1_reg <= item_in;
            pw1_reg   <= 32'((48'(cfg.glyph_scale) * 48'(in_w)) >> 16);
        end
        if (adv2 && valid1_reg) begin
            item2_reg <= item2_next;
        end
    end

    assign out_valid = valid2_reg;
    assign out_item  = item2_reg;

endmodule

`default_nettype wire

>>> rtl/tgl_queue.sv
// ---------------------------------------------------------------------------
// tgl_queue
// short first-in first-out queue between the front and the back
// ---------------------------------------------------------------------------
`default_nettype none

module tgl_queue #(
    parameter int DEPTH = tgl_pkg::TGL_QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tgl_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tgl_pkg::item_t       out_item
);
    import tgl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t             store_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = store_mem[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tgl_back.sv
// ---------------------------------------------------------------------------
// tgl_back
// cursor, colour and escape state; places glyphs into the result register
// ---------------------------------------------------------------------------
`default_nettype none
`include "text_glyph_layout_assert.svh"

module tgl_back #(
    parameter int MAX_GLYPHS = tgl_pkg::TGL_MAX_GLYPHS
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tgl_pkg::cfg_t   cfg,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire tgl_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output tgl_pkg::result_t     out_result
);
    import tgl_pkg::*;

    localparam int CNT_W = $clog2(MAX_GLYPHS + 1);

    logic [31:0]      cursor_x_reg, cursor_x_next;
    logic [31:0]      cursor_y_reg, cursor_y_next;
    logic [2:0]       colour_reg, colour_next;
    logic [2:0]       level_reg, level_next;
    logic             escape_reg, escape_next;
    logic             stopped_reg, stopped_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg;
    result_t          result_reg;

    logic [31:0]      cx, cy;
    logic [2:0]       colour_cur, level_cur;
    logic             escape_cur, stopped_cur;
    logic [CNT_W-1:0] count_cur;
    logic [CNT_W+9:0] slot_ext;
    logic             active, do_emit, pop;
    result_t          result_new;

    assign pop      = in_valid && (!out_valid_reg || out_ready);
    assign in_ready = !out_valid_reg || out_ready;

    // a new string starts from the reset state of the string
    always_comb begin
        if (in_item.new_string) begin
            cx          = cfg.start_x;
            cy          = cfg.start_y;
            colour_cur  = COLOUR_WHITE;
            level_cur   = LEVEL_FULL;
            escape_cur  = 1'b0;
            stopped_cur = 1'b0;
            count_cur   = '0;
        end else begin
            cx          = cursor_x_reg;
            cy          = cursor_y_reg;
            colour_cur  = colour_reg;
            level_cur   = level_reg;
            escape_cur  = escape_reg;
            stopped_cur = stopped_reg;
            count_cur   = count_reg;
        end
    end

    assign active   = !stopped_cur && (count_cur < CNT_W'(MAX_GLYPHS));
    assign slot_ext = {10'd0, count_cur};

    always_comb begin
        cursor_x_next = cx;
        cursor_y_next = cy;
        colour_next   = colour_cur;
        level_next    = level_cur;
        escape_next   = escape_cur;
        stopped_next  = stopped_cur;
        count_next    = count_cur;
        do_emit       = 1'b0;
        if (active) begin
            if (escape_cur) begin
                escape_next = 1'b0;
                unique case (in_item.esc_kind)
                    ESC_COLOUR: colour_next = in_item.esc_value;
                    ESC_LEVEL:  level_next  = in_item.esc_value;
                    default:    do_emit     = 1'b1;
                endcase
            end else begin
                unique case (in_item.kind)
                    KIND_NEWLINE: begin
                        cursor_x_next = cfg.start_x;
                        cursor_y_next = cy + {1'b0, cfg.line_size};
                    end
                    KIND_RETURN:    cursor_x_next = cfg.start_x;
                    KIND_BACKSPACE: cursor_x_next = cx - {2'b00, cfg.line_size[30:1]};
                    KIND_ESCAPE:    escape_next   = 1'b1;
                    KIND_NUL:       stopped_next  = 1'b1;
                    default:        do_emit       = 1'b1;
                endcase
            end
            if (do_emit) begin
                cursor_x_next = cx + in_item.quad_width;
                count_next    = count_cur + CNT_W'(1);
            end
        end
    end

    always_comb begin
        result_new.icon_slot       = slot_ext[9:0];
        result_new.pos_x           = cx;
        result_new.pos_y           = cy;
        result_new.quad_width      = in_item.quad_width;
        result_new.quad_height     = in_item.quad_height;
        result_new.tex_left        = in_item.tex_left;
        result_new.tex_bottom      = in_item.tex_bottom;
        result_new.tex_width       = in_item.tex_width;
        result_new.tex_height      = in_item.tex_height;
        result_new.colour_bits     = colour_cur;
        result_new.intensity_level = level_cur;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg  <= RST_START_X;
            cursor_y_reg  <= RST_START_Y;
            colour_reg    <= COLOUR_WHITE;
            level_reg     <= LEVEL_FULL;
            escape_reg    <= 1'b0;
            stopped_reg   <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                cursor_x_reg  <= cursor_x_next;
                cursor_y_reg  <= cursor_y_next;
                colour_reg    <= colour_next;
                level_reg     <= level_next;
                escape_reg    <= escape_next;
                stopped_reg   <= stopped_next;
                count_reg     <= count_next;
                out_valid_reg <= do_emit;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && do_emit) begin
            result_reg <= result_new;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // glyph count stays within the store
    `TGL_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_GLYPHS))
    // a placed glyph shows up as a result beat with its slot
    `TGL_ASSERT_NEXT(a_emit_beat, aclk, aresetn, pop && do_emit,
        out_valid_reg && result_reg.icon_slot == $past(slot_ext[9:0]))
    // a stopped string leaves the cursor alone
    `TGL_ASSERT_NEXT(a_stopped_hold, aclk, aresetn, pop && !in_item.new_string && stopped_reg,
        $stable(cursor_x_reg) && $stable(cursor_y_reg) && $stable(count_reg))

endmodule

`default_nettype wire

>>> rtl/text_glyph_layout.sv
// ---------------------------------------------------------------------------
// text_glyph_layout
// places text glyphs: cursor, colour and intensity escapes, quad sizing
// ---------------------------------------------------------------------------
//
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+----------------------------------
// s_axis    | in  | s_axis_tvalid/tready   | tdata 72b characters, tuser string start
// m_axis    | out | m_axis_tvalid/tready   | tdata 208b placed glyph
// cfg       | in  | cfg_valid/cfg_ready    | cfg_index 3b, cfg_data 32b
//
// one character per cycle sustained while m_axis does not stall; the cursor add in the back
// sets that rate; a beat passes from s_axis to m_axis through two multiply stages in
// the front, the queue, then the back's result register
// aresetn is synchronous; it clears control state and the configuration registers, no sweep
// either side may stall; the queue and the result register keep them apart
//
`default_nettype none

module text_glyph_layout #(
    parameter int MAX_GLYPHS = tgl_pkg::TGL_MAX_GLYPHS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [tgl_pkg::TGL_CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [31:0]                        cfg_data,
    // characters in
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // char_code[7:0], glyph_u[23:8], glyph_v[39:24], glyph_w[55:40], glyph_h[71:56]
    input  wire logic [71:0]                        s_axis_tdata,
    // new_string[0]
    input  wire logic                               s_axis_tuser,
    // placed glyphs out
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // icon_slot[9:0], pos_x[41:10], pos_y[73:42], quad_width[105:74],
    // quad_height[137:106], tex_left[153:138], tex_bottom[169:154],
    // tex_width[185:170], tex_height[201:186], colour_bits[204:202],
    // intensity_level[207:205]
    output logic [207:0]                            m_axis_tdata
);
    import tgl_pkg::*;

    cfg_t    cfg_reg;
    logic    fr_valid, fr_ready;
    item_t   fr_item;
    logic    q_valid, q_ready;
    item_t   q_item;
    result_t result;

    // registers take writes at any time; the user writes only while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_x     <= RST_START_X;
            cfg_reg.start_y     <= RST_START_Y;
            cfg_reg.line_size   <= RST_LINE_SIZE;
            cfg_reg.glyph_scale <= RST_GLYPH_SCALE;
            cfg_reg.inv_aspect  <= RST_INV_ASPECT;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_START_X:     cfg_reg.start_x     <= cfg_data;
                CFG_START_Y:     cfg_reg.start_y     <= cfg_data;
                CFG_LINE_SIZE:   cfg_reg.line_size   <= cfg_data[30:0];
                CFG_GLYPH_SCALE: cfg_reg.glyph_scale <= cfg_data;
                CFG_INV_ASPECT:  cfg_reg.inv_aspect  <= cfg_data;
                default:         ; // unused indexes are dropped
            endcase
        end
    end

    // front: decode characters and size the quad
    tgl_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_new_string (s_axis_tuser),
        .in_char       (s_axis_tdata[7:0]),
        .in_u          (s_axis_tdata[23:8]),
        .in_v          (s_axis_tdata[39:24]),
        .in_w          (s_axis_tdata[55:40]),
        .in_h          (s_axis_tdata[71:56]),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_item      (fr_item)
    );

    // queue decouples the multiply pipeline from the cursor loop
    tgl_queue #(
        .DEPTH (TGL_QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // back: string state and result register
    tgl_back #(
        .MAX_GLYPHS (MAX_GLYPHS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    // pack the result beat, first field in the low bits
    assign m_axis_tdata = {result.intensity_level, result.colour_bits,
                           result.tex_height, result.tex_width,
                           result.tex_bottom, result.tex_left,
                           result.quad_height, result.quad_width,
                           result.pos_y, result.pos_x, result.icon_slot};

endmodule

`default_nettype wire
